[hdl/lru_key_value_cache_defines.svh]
// assertion helpers for the lru cache
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`define LKV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LKV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/lkv_pkg.sv]
`default_nettype none
package lkv_pkg;

  localparam int CAP_DEF = 16;
  localparam int CFG_W   = 5;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 31;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkv_in_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value_out;
    logic             evicted;
  } lkv_out_t;

  typedef struct packed {
    logic             is_put;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkv_cmd_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } lkv_q_ctl_t;

endpackage
`default_nettype wire

[hdl/lkv_front.sv]
`default_nettype none
module lkv_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire lkv_pkg::lkv_in_t in_word,
  input  wire logic             pop,
  output lkv_pkg::lkv_q_ctl_t   q_ctl,
  output lkv_pkg::lkv_cmd_t     cmd
);
  import lkv_pkg::*;

  lkv_cmd_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, do_pop;

  assign busy   = (cnt_r == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != 2'd0);
  assign cmd    = q_r[rp_r];
  assign q_ctl.valid = (cnt_r != 2'd0);
  assign q_ctl.pop   = do_pop;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{is_put: in_word.mode, key: in_word.key, value: in_word.value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

[hdl/lkv_back.sv]
`default_nettype none
`include "lru_key_value_cache_defines.svh"
module lkv_back #(
  parameter int CAP = lkv_pkg::CAP_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [lkv_pkg::CFG_W-1:0] cap_cfg,
  input  wire lkv_pkg::lkv_q_ctl_t       q_ctl,
  input  wire lkv_pkg::lkv_cmd_t         cmd,
  output logic                           pop,
  output logic                           out_strobe,
  output lkv_pkg::lkv_out_t              out_word
);
  import lkv_pkg::*;

  localparam int IW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CW = $clog2(CAP + 1);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [2:0] {S_IDLE, S_SRCH, S_ACT, S_VRD} state_t;

  state_t            state_r;
  lkv_cmd_t          cmd_r;
  logic [KEY_W-1:0]  key_mem [CAP];
  logic [VAL_W-1:0]  val_mem [CAP];
  logic [KEY_W-1:0]  key_rd_r;
  logic [VAL_W-1:0]  val_rd_r;
  logic [CAP-1:0]    valid_r;
  logic [IW-1:0]     age_r [CAP];
  logic [CW-1:0]     used_r;
  logic [IW:0]       cnt_r;
  logic              dv_r;
  logic [IW-1:0]     didx_r;
  logic              hit_r, free_have_r, old_have_r;
  logic [IW-1:0]     slot_r, free_r, old_r;
  logic              out_valid_r;
  lkv_out_t          out_r;
  logic [CAP-1:0]    old_v;
  logic [EW-1:0]     eff_cap, used_ext;
  logic              full;
  logic [IW-1:0]     tgt;
  logic              use_lim;
  logic [IW-1:0]     lim;
  logic              wr_en, issue;

  assign pop        = (state_r == S_IDLE) && q_ctl.valid;
  assign out_strobe = out_valid_r;
  assign out_word   = out_r;
  assign issue      = (state_r == S_SRCH) && (cnt_r < (IW+1)'(CAP));

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      old_v[i] = valid_r[i] && ({{(CW-IW){1'b0}}, age_r[i]} == used_r - CW'(1));
    end
  end

  always_comb begin
    if (cap_cfg == '0) eff_cap = EW'(1);
    else if (EW'(cap_cfg) > EW'(CAP)) eff_cap = EW'(CAP);
    else eff_cap = EW'(cap_cfg);
  end
  assign used_ext = EW'(used_r);
  assign full     = used_ext >= eff_cap;

  always_comb begin
    tgt     = slot_r;
    use_lim = 1'b1;
    wr_en   = 1'b0;
    if (hit_r) begin
      wr_en = cmd_r.is_put;
    end else if (full) begin
      tgt   = old_r;
      wr_en = cmd_r.is_put;
    end else begin
      tgt     = free_r;
      use_lim = 1'b0;
      wr_en   = cmd_r.is_put;
    end
    lim = age_r[tgt];
  end

  // key/value stores
  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[cnt_r[IW-1:0]];
    val_rd_r <= val_mem[slot_r];
    if ((state_r == S_ACT) && wr_en) begin
      val_mem[tgt] <= cmd_r.value;
      if (!hit_r) key_mem[tgt] <= cmd_r.key;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      used_r      <= '0;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      didx_r      <= '0;
      hit_r       <= 1'b0;
      free_have_r <= 1'b0;
      old_have_r  <= 1'b0;
      slot_r      <= '0;
      free_r      <= '0;
      old_r       <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      for (int i = 0; i < CAP; i++) age_r[i] <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            cnt_r       <= '0;
            dv_r        <= 1'b0;
            hit_r       <= 1'b0;
            free_have_r <= 1'b0;
            old_have_r  <= 1'b0;
            state_r     <= S_SRCH;
          end
        end
        S_SRCH: begin
          dv_r   <= issue;
          didx_r <= cnt_r[IW-1:0];
          if (issue) cnt_r <= cnt_r + (IW+1)'(1);
          if (dv_r) begin
            if (valid_r[didx_r] && (key_rd_r == cmd_r.key) && !hit_r) begin
              hit_r  <= 1'b1;
              slot_r <= didx_r;
            end
            if (!valid_r[didx_r] && !free_have_r) begin
              free_have_r <= 1'b1;
              free_r      <= didx_r;
            end
            if (old_v[didx_r] && !old_have_r) begin
              old_have_r <= 1'b1;
              old_r      <= didx_r;
            end
          end
          if (!issue && !dv_r) state_r <= S_ACT;
        end
        S_ACT: begin
          if (hit_r || cmd_r.is_put) begin
            for (int i = 0; i < CAP; i++) begin
              if ((IW'(i) != tgt) && valid_r[i] && (!use_lim || (age_r[i] < lim))) begin
                age_r[i] <= age_r[i] + IW'(1);
              end
            end
            age_r[tgt] <= '0;
          end
          if (!hit_r && cmd_r.is_put && !full) begin
            valid_r[tgt] <= 1'b1;
            used_r       <= used_r + CW'(1);
          end
          if (hit_r && !cmd_r.is_put) begin
            state_r <= S_VRD;
          end else begin
            out_valid_r       <= 1'b1;
            out_r.found       <= hit_r;
            out_r.value_out   <= '0;
            out_r.evicted     <= !hit_r && cmd_r.is_put && full;
            state_r           <= S_IDLE;
          end
        end
        S_VRD: begin
          out_valid_r     <= 1'b1;
          out_r.found     <= 1'b1;
          out_r.value_out <= val_rd_r;
          out_r.evicted   <= 1'b0;
          state_r         <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `LKV_ASSERT(a_evict_miss, out_strobe |-> !(out_word.evicted && out_word.found), "evict on hit")
  `LKV_ASSERT(a_used_max, used_r <= CW'(CAP), "occupancy above depth")
  `LKV_ASSERT(a_strobe_src, out_strobe |-> ($past(state_r) == S_ACT || $past(state_r) == S_VRD), "stray result")
  `LKV_ASSERT(a_val_hit, (out_strobe && out_word.value_out != '0) |-> out_word.found, "value without hit")
  `LKV_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe, "result after reset")
endmodule
`default_nettype wire

[hdl/lru_key_value_cache.sv]
// an accepted word waits in the queue before the key store sweep; a get that hits adds a value read state
// the back end takes a new word only after the result of the last one; its key store sweep visits all CAP slots
// a two-deep queue takes up to two words while the sweep runs; busy when it is full
// the receiver cannot stall; each result shows for one cycle with out_strobe
// synchronous reset empties the cache, clears the queue and sets capacity to 16
`default_nettype none
module lru_key_value_cache #(
  parameter int CAP = lkv_pkg::CAP_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire lkv_pkg::lkv_in_t          in_word,
  output logic                           out_strobe,
  output lkv_pkg::lkv_out_t              out_word,
  input  wire logic                      cfg_we,
  input  wire logic [lkv_pkg::CFG_W-1:0] cfg_wdata
);
  import lkv_pkg::*;

  logic [CFG_W-1:0] cap_r;
  lkv_q_ctl_t       q_ctl;
  lkv_cmd_t         cmd;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  lkv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .pop     (pop),
    .q_ctl   (q_ctl),
    .cmd     (cmd)
  );

  lkv_back #(.CAP(CAP)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap_cfg    (cap_r),
    .q_ctl      (q_ctl),
    .cmd        (cmd),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );
endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import lkv_pkg::*;

  localparam int NSLOT = CAP_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lkv_in_t in_word = '0;
  logic out_strobe;
  lkv_out_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  lru_key_value_cache dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cache shadow
  logic [KEY_W-1:0] sh_key [NSLOT];
  logic [VAL_W-1:0] sh_val [NSLOT];
  logic sh_valid [NSLOT];
  int unsigned sh_age [NSLOT];
  int unsigned sh_used;
  int unsigned sh_cap;

  lkv_in_t pending_words[$];
  lkv_out_t expected_words[$];
  int errors = 0;
  bit drv_idle = 1'b1;
  int burst_left = 0;
  int gap_left = 0;

  function automatic void touch_slot(int s, bit was_valid);
    int unsigned lim;
    lim = was_valid ? sh_age[s] : 32'hFFFF_FFFF;
    for (int i = 0; i < NSLOT; i++)
      if (i != s && sh_valid[i] && sh_age[i] < lim) sh_age[i]++;
    sh_age[s] = 0;
  endfunction

  function automatic lkv_out_t cache_access(lkv_in_t w);
    lkv_out_t r;
    int slot;
    int unsigned ec;
    bit have;
    r = '0;
    slot = -1;
    for (int i = 0; i < NSLOT; i++)
      if (slot < 0 && sh_valid[i] && sh_key[i] == w.key) slot = i;
    if (slot >= 0) begin
      r.found = 1'b1;
      if (!w.mode) r.value_out = sh_val[slot];
      else sh_val[slot] = w.value;
      touch_slot(slot, 1'b1);
    end else if (w.mode) begin
      ec = (sh_cap < 1) ? 1 : (sh_cap > NSLOT ? NSLOT : sh_cap);
      if (sh_used >= ec) begin
        have = 1'b0;
        slot = 0;
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && (!have || sh_age[i] > sh_age[slot])) begin
            slot = i;
            have = 1'b1;
          end
        r.evicted = 1'b1;
        sh_key[slot] = w.key;
        sh_val[slot] = w.value;
        touch_slot(slot, 1'b1);
      end else begin
        for (int i = NSLOT - 1; i >= 0; i--)
          if (!sh_valid[i]) slot = i;
        sh_key[slot] = w.key;
        sh_val[slot] = w.value;
        touch_slot(slot, 1'b0);
        sh_valid[slot] = 1'b1;
        sh_used++;
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (start && !busy) begin
      expected_words.push_back(cache_access(in_word));
    end
    if (!rst_n || (start && busy)) begin
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_words.size() > 0) begin
      in_word <= pending_words.pop_front();
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) drv_idle <= pending_words.size() == 0 && !start;

  // monitor
  always @(posedge clk) begin
    lkv_out_t e;
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word found=%0d value_out=%0d evicted=%0d",
               out_word.found, out_word.value_out, out_word.evicted);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_word.found !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_word.found);
          errors++;
        end
        if (out_word.value_out !== e.value_out) begin
          $error("value_out exp %0d got %0d", e.value_out, out_word.value_out);
          errors++;
        end
        if (out_word.evicted !== e.evicted) begin
          $error("evicted exp %0d got %0d", e.evicted, out_word.evicted);
          errors++;
        end
      end
    end
  end

  function automatic lkv_in_t mk(bit m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    lkv_in_t w;
    w.mode = m;
    w.key = k;
    w.value = v;
    return w;
  endfunction

  task automatic drain();
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (!drv_idle || expected_words.size() != 0) @(posedge clk);
    repeat (3 * (NSLOT + 6)) @(posedge clk);
  endtask

  task automatic set_capacity(int unsigned c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c[CFG_W-1:0];
    sh_cap = c & 32'h1F;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned caps [7] = '{16, 1, 0, 31, 4, 17, 9};
    int unsigned pool;
    logic [KEY_W-1:0] keys [24];
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 1'b0;
      sh_age[i] = 0;
      sh_key[i] = '0;
      sh_val[i] = '0;
    end
    sh_used = 0;
    sh_cap = CAP_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: miss, insert, hit, update, extreme fields, eviction
    pending_words.push_back(mk(1'b0, 32'h0, '0));
    pending_words.push_back(mk(1'b1, 32'h0, '0));
    pending_words.push_back(mk(1'b0, 32'h0, '1));
    pending_words.push_back(mk(1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    pending_words.push_back(mk(1'b0, 32'hFFFF_FFFF, '0));
    pending_words.push_back(mk(1'b1, 32'hFFFF_FFFF, 31'h5555_5555));
    pending_words.push_back(mk(1'b0, 32'hFFFF_FFFF, '0));
    for (int i = 0; i < 16; i++) pending_words.push_back(mk(1'b1, KEY_W'(100 + i), VAL_W'(i)));
    pending_words.push_back(mk(1'b0, 32'h0, '0));
    pending_words.push_back(mk(1'b0, 32'hFFFF_FFFF, '0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) set_capacity(caps[(ph - 1) % 7]);
      pool = $urandom_range(2, 24);
      for (int i = 0; i < 24; i++) keys[i] = $urandom();
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(0, 9) == 0)
          pending_words.push_back(mk(1'($urandom_range(0, 1)), $urandom(),
                                     VAL_W'($urandom())));
        else
          pending_words.push_back(mk(1'($urandom_range(0, 1)),
                                     keys[$urandom_range(0, pool - 1)],
                                     VAL_W'($urandom())));
      end
      drain();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
